FILE: rtl/core/cdr_primitive_serializer_top_assert.svh
// ============================================================================
// CDR primitive serializer assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef CDR_PRIMITIVE_SERIALIZER_TOP_ASSERT_SVH
`define CDR_PRIMITIVE_SERIALIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cps same-cycle check failed");
`define CPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cps next-cycle check failed");
`else
`define CPS_ASSERT_SAME(label, ante, cons)
`define CPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/cps_pkg.sv
// ============================================================================
// CDR primitive serializer package
// Item types, queue command type and operation codes.
// ============================================================================
package cps_pkg;

    localparam int POS_W = 17;
    localparam int CAP_W = 17;
    localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_ALIGN = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] value;
        logic [1:0]  size_code;
        logic        big_endian;
    } item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_padding;
        logic        overflow;
        logic [15:0] byte_position;
        logic        last;
    } result_t;

    // classified work handed from front to back
    typedef struct packed {
        logic        overflow;
        logic [2:0]  pad_cnt;
        logic [3:0]  val_cnt;
        logic [63:0] value;
        logic        big_endian;
        logic [15:0] start_pos;
    } cmd_t;

endpackage

FILE: rtl/core/cps_front.sv
// ============================================================================
// CDR serializer front end
// Accepts items, tracks the write position, computes padding and the fit
// test, and pushes one command per item that produces results.
// ============================================================================
module cps_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  cps_pkg::item_t                 item,
    input  logic [cps_pkg::CAP_W-1:0]      eff_cap,
    input  logic                           queue_full,
    output logic                           push,
    output cps_pkg::cmd_t                  push_cmd
);

    logic [cps_pkg::POS_W-1:0] pos_reg;
    logic [cps_pkg::POS_W-1:0] pos_next;
    logic                      accept;
    logic [3:0]                size4;
    logic [2:0]                mask;
    logic [2:0]                pad;
    logic [3:0]                need;
    logic                      is_write;
    logic                      emit_op;
    logic                      fits;
    logic                      emit;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        size4    = 4'd1 << item.size_code;
        mask     = 3'(size4 - 4'd1);
        pad      = (3'd0 - pos_reg[2:0]) & mask;
        is_write = (item.operation == cps_pkg::OP_WRITE);
        emit_op  = item.operation inside {cps_pkg::OP_WRITE, cps_pkg::OP_ALIGN};
        need     = {1'b0, pad} + (is_write ? size4 : 4'd0);
        fits     = ({1'b0, pos_reg} + 18'(need)) <= {1'b0, eff_cap};
        emit     = emit_op && (need != 4'd0);

        push                = accept && emit;
        push_cmd.overflow   = !fits;
        push_cmd.pad_cnt    = pad;
        push_cmd.val_cnt    = is_write ? size4 : 4'd0;
        push_cmd.value      = item.value;
        push_cmd.big_endian = item.big_endian;
        push_cmd.start_pos  = pos_reg[15:0];

        pos_next = pos_reg;
        if (accept)
        begin
            case (item.operation)
                cps_pkg::OP_RESET:
                    pos_next = '0;
                cps_pkg::OP_WRITE, cps_pkg::OP_ALIGN:
                    if (emit && fits)
                    begin
                        pos_next = pos_reg + cps_pkg::POS_W'(need);
                    end
                default:
                    pos_next = pos_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/core/cps_queue.sv
// ============================================================================
// CDR serializer command queue
// Two-entry shift queue; the head always sits in the first entry.
// ============================================================================
module cps_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cps_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output cps_pkg::cmd_t head
);

    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    cps_pkg::cmd_t entry0_reg;
    cps_pkg::cmd_t entry0_next;
    cps_pkg::cmd_t entry1_reg;
    cps_pkg::cmd_t entry1_next;

    assign full       = count_reg[1];
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry0_reg;

    always_comb
    begin
        count_next  = count_reg;
        entry0_next = entry0_reg;
        entry1_next = entry1_reg;
        case (count_reg)
            2'd0:
                if (push)
                begin
                    entry0_next = push_cmd;
                    count_next  = 2'd1;
                end
            2'd1:
                if (push && pop)
                begin
                    entry0_next = push_cmd;
                end
                else if (push)
                begin
                    entry1_next = push_cmd;
                    count_next  = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            2'd2:
                if (pop)
                begin
                    entry0_next = entry1_reg;
                    count_next  = 2'd1;
                end
            default:
                count_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry0_reg <= entry0_next;
        entry1_reg <= entry1_next;
    end

endmodule

FILE: rtl/core/cps_back.sv
// ============================================================================
// CDR serializer back end
// Walks one command a byte per cycle while stream_ready holds: padding, then
// value bytes, or a single overflow item. Output register decouples the stream side.
// ============================================================================
module cps_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  cps_pkg::cmd_t    head,
    output logic             pop,
    output logic             stream_valid,
    input  logic             stream_ready,
    output cps_pkg::result_t stream
);

    logic             busy_reg;
    logic             busy_next;
    cps_pkg::cmd_t    cur_reg;
    cps_pkg::cmd_t    cur_next;
    logic [2:0]       pad_left_reg;
    logic [2:0]       pad_left_next;
    logic [3:0]       val_idx_reg;
    logic [3:0]       val_idx_next;
    logic [15:0]      pos_reg;
    logic [15:0]      pos_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    cps_pkg::result_t out_reg;
    cps_pkg::result_t out_next;
    cps_pkg::result_t res;
    logic             load;
    logic             done;
    logic [2:0]       bsel;

    assign stream_valid = out_valid_reg;
    assign stream       = out_reg;
    assign load         = busy_reg && (!out_valid_reg || stream_ready);

    always_comb
    begin
        res.byte_position = pos_reg;
        res.overflow      = 1'b0;
        res.is_padding    = 1'b0;
        res.data_byte     = 8'd0;
        bsel = cur_reg.big_endian ? 3'(cur_reg.val_cnt - 4'd1 - val_idx_reg)
                                  : val_idx_reg[2:0];
        if (cur_reg.overflow)
        begin
            res.overflow = 1'b1;
            res.last     = 1'b1;
        end
        else if (pad_left_reg != 3'd0)
        begin
            res.is_padding = 1'b1;
            res.last       = (cur_reg.val_cnt == 4'd0) && (pad_left_reg == 3'd1);
        end
        else
        begin
            res.data_byte = cur_reg.value[{bsel, 3'b000} +: 8];
            res.last      = ((val_idx_reg + 4'd1) == cur_reg.val_cnt);
        end
        done = res.last;
        pop  = head_valid && (!busy_reg || (load && done));
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        pad_left_next  = pad_left_reg;
        val_idx_next   = val_idx_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
            pos_next       = pos_reg + 16'd1;
            if (done)
            begin
                busy_next = 1'b0;
            end
            else if (pad_left_reg != 3'd0)
            begin
                pad_left_next = pad_left_reg - 3'd1;
            end
            else
            begin
                val_idx_next = val_idx_reg + 4'd1;
            end
        end
        else if (stream_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            busy_next     = 1'b1;
            cur_next      = head;
            pad_left_next = head.pad_cnt;
            val_idx_next  = 4'd0;
            pos_next      = head.start_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pad_left_reg <= pad_left_next;
        val_idx_reg  <= val_idx_next;
        pos_reg      <= pos_next;
        out_reg      <= out_next;
    end

endmodule

FILE: rtl/core/cdr_primitive_serializer_top.sv
// ============================================================================
// CDR primitive serializer
// An accepted item's first result passes the queue, command and output registers.
// Stream side emits one byte per cycle while stream_ready allows: a write
// of size S with P padding bytes yields P + S items, an align P, an overflow one.
// Front accepts one item per cycle while the two-entry queue has room.
// Reset clears the write position and queue; capacity returns to 65536.
// ============================================================================
`include "cdr_primitive_serializer_top_assert.svh"

module cdr_primitive_serializer_top #(
    parameter longint unsigned MAX_BUFFER_BYTES = 65536
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  cps_pkg::item_t            item,
    output logic                      stream_valid,
    input  logic                      stream_ready,
    output cps_pkg::result_t          stream,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cps_pkg::CAP_W-1:0] cfg_data
);

    localparam logic [cps_pkg::CAP_W-1:0] MaxCap =
        (MAX_BUFFER_BYTES > longint'((1 << cps_pkg::CAP_W) - 1))
            ? {cps_pkg::CAP_W{1'b1}} : cps_pkg::CAP_W'(MAX_BUFFER_BYTES);

    logic [cps_pkg::CAP_W-1:0] cap_reg;
    logic [cps_pkg::CAP_W-1:0] cap_next;
    logic [cps_pkg::CAP_W-1:0] eff_cap;
    logic                      queue_full;
    logic                      push;
    cps_pkg::cmd_t             push_cmd;
    logic                      pop;
    logic                      head_valid;
    cps_pkg::cmd_t             head;

    assign cfg_ready = 1'b1;
    assign cap_next  = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;
    assign eff_cap   = (cap_reg < MaxCap) ? cap_reg : MaxCap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= cps_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    cps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .eff_cap    (eff_cap),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    cps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .stream_valid (stream_valid),
        .stream_ready (stream_ready),
        .stream       (stream)
    );

    // overflow item is a lone, zeroed, final item
    `CPS_ASSERT_SAME(a_ovf_shape, stream_valid && stream.overflow, stream.last && (stream.data_byte == 8'd0) && !stream.is_padding)
    // padding carries zero data
    `CPS_ASSERT_SAME(a_pad_zero, stream_valid && stream.is_padding, (stream.data_byte == 8'd0) && !stream.overflow)
    // bytes of one item follow without gaps at consecutive offsets
    `CPS_ASSERT_NEXT(a_pos_step, stream_valid && stream_ready && !stream.last, stream_valid && (stream.byte_position == 16'($past(stream.byte_position) + 16'd1)))

endmodule
